[hdl/compression_stroke_detector_defines.svh]
// ----------------------------------------------------------------------------
// Compression stroke detector assertion macros
// Shared property wrappers for the top level checks.
// ----------------------------------------------------------------------------
`ifndef COMPRESSION_STROKE_DETECTOR_DEFINES_SVH
`define COMPRESSION_STROKE_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off during reset
`define CSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("csd: check failed");

// Next-cycle implication, sampled on i_clk, held off during reset
`define CSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("csd: check failed");

`endif

[hdl/csd_pkg.sv]
// ----------------------------------------------------------------------------
// csd_pkg
// Types, register indexes, state codes and constants of the stroke detector.
// ----------------------------------------------------------------------------
package csd_pkg;

    // Field widths
    localparam int DEPTH_W  = 10;
    localparam int RATE_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Default parameter values
    localparam int DEPTH_FRAC_BITS_DEF = 4;
    localparam int TIME_WIDTH_DEF      = 32;

    // Rate numerator: milliseconds per minute
    localparam logic [RATE_W-1:0] RATE_NUM = 16'd60000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_RISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DROP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = 2'd2;

    // Configuration reset values, 1/16 mm units
    localparam logic [DEPTH_W-1:0] START_RISE_RST = 10'd112;
    localparam logic [DEPTH_W-1:0] PEAK_DROP_RST  = 10'd80;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST  = 10'd1016;

    // Motion state codes
    localparam logic [MODE_W-1:0] MODE_IDLE        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPRESSING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASING   = 2'd2;

    // Input transaction
    typedef struct packed {
        logic               sample_valid;
        logic [DEPTH_W-1:0] depth_mm;
        logic [STAMP_W-1:0] now_ms;
    } t_csd_in;

    // Output transaction
    typedef struct packed {
        logic               stroke_started;
        logic               stroke_completed;
        logic [MODE_W-1:0]  stroke_phase;
        logic [DEPTH_W-1:0] raw_depth;
        logic [DEPTH_W-1:0] filtered_depth;
        logic [DEPTH_W-1:0] start_depth;
        logic [DEPTH_W-1:0] peak_depth;
        logic [RATE_W-1:0]  beat_rate;
        logic [STAMP_W-1:0] last_stroke_ms;
    } t_csd_out;

endpackage

[hdl/csd_rate_div.sv]
// ----------------------------------------------------------------------------
// csd_rate_div
// Serial restoring divider: RATE_NUM / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csd_rate_div
    import csd_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [RATE_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(RATE_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_WIDTH-1:0] r_div;
    logic [TIME_WIDTH-1:0] r_rem;
    logic [RATE_W-1:0]     r_quo;

    // Shared compare/subtract step
    logic [TIME_WIDTH:0] rem_sh;
    logic                ge;
    logic [TIME_WIDTH:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[RATE_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RATE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= RATE_NUM;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
            r_quo <= {r_quo[RATE_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/compression_stroke_detector.sv]
// ----------------------------------------------------------------------------
// compression_stroke_detector
// Filters depth samples and detects compression strokes and their rate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one sample
//   per transaction. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one result per sample, in order.
//   Configuration: i_cfg_we writes i_cfg_wdata into the register selected
//   by i_cfg_addr (start_rise, peak_drop, max_depth); write only when idle.
// Sequence:
//   Invalid sample: from acceptance straight to the output load.
//   Valid sample: filter step, tracking step, output load, in order.
//   A completed stroke with a known earlier completion adds the serial
//   rate divider (one quotient bit per cycle, 16 bits) before the load.
//   One sample is in work at a time; o_in_ready is high while the
//   sequencer is idle, so a new sample waits until the last is loaded.
// Reset: synchronous, active low; clears the tracker state and restores
//   the configuration defaults. No result is pending after reset.
// Stall: the result register holds its transaction until taken; a new
//   sample may be accepted and worked on meanwhile, and the sequencer
//   waits before loading the next result while the register is full.
// ----------------------------------------------------------------------------
`include "compression_stroke_detector_defines.svh"

module compression_stroke_detector
    import csd_pkg::*;
#(
    parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF,
    parameter int TIME_WIDTH      = TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_csd_in              i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_csd_out             o_out_data,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [DEPTH_W-1:0]   i_cfg_wdata
);

    localparam int SHIFT_W = DEPTH_W + DEPTH_FRAC_BITS;
    localparam int NOW_W   = (TIME_WIDTH < STAMP_W) ? TIME_WIDTH : STAMP_W;

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILT  = 3'd1;
    localparam logic [2:0] ST_TRACK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration registers
    logic [DEPTH_W-1:0] r_start_rise;
    logic [DEPTH_W-1:0] r_peak_drop;
    logic [DEPTH_W-1:0] r_max_depth;

    // Tracker state
    logic [MODE_W-1:0]     r_mode;
    logic [DEPTH_W-1:0]    r_smoothed;
    logic [DEPTH_W-1:0]    r_recoil;
    logic [DEPTH_W-1:0]    r_base;
    logic [DEPTH_W-1:0]    r_raw_peak;
    logic [DEPTH_W-1:0]    r_sm_peak;
    logic [TIME_WIDTH-1:0] r_prev;
    logic [DEPTH_W-1:0]    r_held_raw;
    logic [DEPTH_W-1:0]    r_held_start;
    logic [DEPTH_W-1:0]    r_held_peak;
    logic [RATE_W-1:0]     r_held_rate;

    // Captured sample and event flags
    logic [DEPTH_W-1:0]    r_raw_mm;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_started;
    logic                  r_completed;

    // Result register
    logic     r_out_valid;
    t_csd_out r_out_data;

    logic in_acc;
    logic out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Filter step: scale, clamp, quarter-weight recursion, clamp again
    logic [SHIFT_W-1:0] raw_scaled;
    logic [DEPTH_W-1:0] raw_clamped;
    logic [DEPTH_W+1:0] filt_sum;
    logic [DEPTH_W-1:0] filt_q;
    logic [DEPTH_W-1:0] filt_clamped;

    assign raw_scaled  = {r_raw_mm, {DEPTH_FRAC_BITS{1'b0}}};
    assign raw_clamped = (raw_scaled > SHIFT_W'(r_max_depth)) ? r_max_depth
                                                              : raw_scaled[DEPTH_W-1:0];
    assign filt_sum    = {2'b00, raw_clamped} + {1'b0, r_smoothed, 1'b0}
                         + {2'b00, r_smoothed};
    assign filt_q      = filt_sum[DEPTH_W+1:2];
    assign filt_clamped = (filt_q > r_max_depth) ? r_max_depth : filt_q;

    // Tracking step, on the freshly filtered values
    logic [DEPTH_W-1:0]    rp_new;
    logic [DEPTH_W-1:0]    sp_new;
    logic                  drop_hit;
    logic [MODE_W-1:0]     mode_rest;
    logic [DEPTH_W-1:0]    rc_new;
    logic                  rise_hit;
    logic [TIME_WIDTH-1:0] dt;
    logic                  need_div;

    assign rp_new    = (r_held_raw > r_raw_peak) ? r_held_raw : r_raw_peak;
    assign sp_new    = (r_smoothed > r_sm_peak) ? r_smoothed : r_sm_peak;
    assign drop_hit  = {1'b0, sp_new} >= ({1'b0, r_smoothed} + {1'b0, r_peak_drop});
    assign mode_rest = (r_mode == MODE_RELEASING) ? MODE_RELEASING : MODE_IDLE;
    assign rc_new    = ((r_smoothed < r_recoil) ||
                        (mode_rest == MODE_IDLE && r_recoil == '0)) ? r_smoothed
                                                                     : r_recoil;
    assign rise_hit  = {1'b0, r_smoothed} >= ({1'b0, rc_new} + {1'b0, r_start_rise});
    assign dt        = r_now - r_prev;
    assign need_div  = (r_prev != '0) && (dt != '0);

    // Rate divider
    logic              div_start;
    logic              div_done;
    logic [RATE_W-1:0] div_quo;

    assign div_start = (r_state == ST_TRACK) && (r_mode == MODE_COMPRESSING)
                       && drop_hit && need_div;

    csd_rate_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_rate_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (dt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_in_data.sample_valid ? ST_FILT : ST_DONE;
                end
            end
            ST_FILT:  n_state = ST_TRACK;
            ST_TRACK: n_state = div_start ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_rise <= START_RISE_RST;
            r_peak_drop  <= PEAK_DROP_RST;
            r_max_depth  <= MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_RISE: r_start_rise <= i_cfg_wdata;
                CFG_PEAK_DROP:  r_peak_drop  <= i_cfg_wdata;
                CFG_MAX_DEPTH:  r_max_depth  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sample capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw_mm <= i_in_data.depth_mm;
            r_now    <= TIME_WIDTH'(i_in_data.now_ms[NOW_W-1:0]);
        end
    end

    // Tracker state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_smoothed   <= '0;
            r_recoil     <= '0;
            r_base       <= '0;
            r_raw_peak   <= '0;
            r_sm_peak    <= '0;
            r_prev       <= '0;
            r_held_raw   <= '0;
            r_held_start <= '0;
            r_held_peak  <= '0;
            r_held_rate  <= '0;
            r_started    <= 1'b0;
            r_completed  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_started   <= 1'b0;
                        r_completed <= 1'b0;
                    end
                end
                ST_FILT: begin
                    r_held_raw <= raw_clamped;
                    r_smoothed <= filt_clamped;
                end
                ST_TRACK: begin
                    if (r_mode == MODE_COMPRESSING) begin
                        r_raw_peak <= rp_new;
                        r_sm_peak  <= sp_new;
                        if (drop_hit) begin
                            r_mode       <= MODE_RELEASING;
                            r_prev       <= r_now;
                            r_completed  <= 1'b1;
                            r_held_start <= r_base;
                            r_held_peak  <= rp_new;
                            r_recoil     <= r_smoothed;
                        end
                    end else begin
                        if (rise_hit) begin
                            r_mode       <= MODE_COMPRESSING;
                            r_recoil     <= rc_new;
                            r_base       <= rc_new;
                            r_held_start <= rc_new;
                            r_raw_peak   <= r_held_raw;
                            r_sm_peak    <= r_smoothed;
                            r_started    <= 1'b1;
                        end else begin
                            r_mode   <= mode_rest;
                            r_recoil <= rc_new;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_held_rate <= div_quo;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_data.stroke_started   <= r_started;
            r_out_data.stroke_completed <= r_completed;
            r_out_data.stroke_phase     <= r_mode;
            r_out_data.raw_depth        <= r_held_raw;
            r_out_data.filtered_depth   <= r_smoothed;
            r_out_data.start_depth      <= r_held_start;
            r_out_data.peak_depth       <= r_held_peak;
            r_out_data.beat_rate        <= r_held_rate;
            r_out_data.last_stroke_ms   <= STAMP_W'(r_prev[NOW_W-1:0]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `CSD_ASSERT_SAME(a_div_only_in_div, div_done, r_state == ST_DIV)
    `CSD_ASSERT_SAME(a_complete_releases, o_out_valid && o_out_data.stroke_completed,
                     o_out_data.stroke_phase == MODE_RELEASING)
    `CSD_ASSERT_NEXT(a_valid_sample_filters, in_acc && i_in_data.sample_valid,
                     r_state == ST_FILT)

endmodule
